### sv/adc_group_sample_batcher_top_assert.svh
// Assertion macros for the ADC group sample batcher.
`ifndef ADC_GROUP_SAMPLE_BATCHER_TOP_ASSERT_SVH
`define ADC_GROUP_SAMPLE_BATCHER_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define AGSB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AGSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/agsb_pkg.sv
// Shared types and constants of the ADC group sample batcher.
package agsb_pkg;
    localparam int NUM_CHANNELS = 16;
    localparam int NUM_GROUPS   = 4;
    localparam int BATCH_MAX    = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_W         = 4;
    localparam int FILL_W       = 4;
    localparam int STORE_DEPTH  = 256;
    localparam int STORE_AW     = 8;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;

    typedef enum logic [1:0] {OP_TICK = 2'd0, OP_SAMPLE = 2'd1, OP_READ = 2'd2,
                              OP_NONE = 2'd3} op_t;
    typedef enum logic [1:0] {KIND_START = 2'd0, KIND_BATCH = 2'd1,
                              KIND_REPLY = 2'd2, KIND_RSVD = 2'd3} kind_t;
    typedef enum logic [1:0] {REG_ENABLE = 2'd0, REG_MASKS = 2'd1,
                              REG_DIVIDERS = 2'd2, REG_SIZES = 2'd3} reg_idx_t;
    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_BATCH, ST_EMIT} state_t;

    // classified work from the front end
    typedef struct packed {
        kind_t                   kind;
        logic [1:0]              grp;      // batch owner
        logic [CH_W-1:0]         ch;
        logic [SAMPLE_BITS-1:0]  value;    // reply value
        logic [FILL_W:0]         count;    // batch length when a flush, 0 none
        logic [NUM_GROUPS-1:0]   starts;   // groups to start, tick items
        logic                    has_out;
    } job_t;

    // result item
    typedef struct packed {
        kind_t                   kind;
        logic [1:0]              grp;
        logic [15:0]             mask;
        logic [CH_W-1:0]         ch;
        logic [SAMPLE_BITS-1:0]  value;
        logic                    last;
    } res_t;
endpackage

### sv/agsb_ram.sv
// Generic single-port-write, registered-read RAM.
module agsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/agsb_front.sv
// Front end: config registers, item classification, counter, fill counts.
module agsb_front import agsb_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_take,
    input  logic [1:0]             opcode,
    input  logic [CH_W-1:0]        channel,
    input  logic [15:0]            raw_value,
    input  logic                   batch_done,
    output logic                   busy,
    output logic                   st_we,
    output logic [STORE_AW-1:0]    st_waddr,
    output logic [SAMPLE_BITS-1:0] st_wdata,
    output logic                   job_valid,
    output job_t                   job,
    output logic [63:0]            masks
);
    logic [NUM_GROUPS-1:0]  enable_reg;
    logic [63:0]            masks_reg;
    logic [31:0]            div_reg;
    logic [19:0]            size_reg;
    logic [15:0]            counter_reg;
    logic [FILL_W-1:0]      fill_reg   [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] latest_reg [NUM_CHANNELS];
    logic [7:0]             res_reg    [NUM_GROUPS];   // counter mod divider
    logic                   rem_busy_reg;
    logic [3:0]             rem_step_reg;
    logic                   batch_pend_reg;

    logic [15:0]            cnt_next;
    logic [NUM_GROUPS-1:0]  starts;
    logic [1:0]             owner;
    logic                   owned;
    logic [FILL_W:0]        fill_inc;
    logic [FILL_W:0]        size_g;
    logic                   flush;
    logic [2:0]             i;
    logic                   cfg_we;
    logic [7:0]             div_eff    [NUM_GROUPS];
    logic [7:0]             res_tick   [NUM_GROUPS];
    logic [8:0]             rem_shift  [NUM_GROUPS];
    logic [7:0]             res_fold   [NUM_GROUPS];

    assign masks     = masks_reg;
    assign cnt_next  = counter_reg + 16'd1;
    assign cfg_ready = !rem_busy_reg;
    assign cfg_we    = cfg_valid && !rem_busy_reg;
    assign busy      = rem_busy_reg || batch_pend_reg;

    // residues follow the counter; a divider write rebuilds them bit by bit
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            div_eff[g] = (div_reg[8*g +: 8] == 8'd0) ? 8'd1 : div_reg[8*g +: 8];
            if ((cnt_next == 16'd0) || (res_reg[g] + 8'd1 == div_eff[g]))
            begin
                res_tick[g] = 8'd0;
            end
            else
            begin
                res_tick[g] = res_reg[g] + 8'd1;
            end
            starts[g] = enable_reg[g] && (res_tick[g] == 8'd0);
            // shift in the next counter bit, subtract the divider if it fits
            rem_shift[g] = {res_reg[g], counter_reg[4'd15 - rem_step_reg]};
            if (rem_shift[g] >= {1'b0, div_eff[g]})
            begin
                res_fold[g] = 8'(rem_shift[g] - {1'b0, div_eff[g]});
            end
            else
            begin
                res_fold[g] = rem_shift[g][7:0];
            end
        end
    end

    // lowest enabled group holding the channel
    always_comb
    begin
        owner = 2'd0;
        owned = 1'b0;
        i     = 3'd0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (enable_reg[g] && masks_reg[16*g + int'(channel)])
            begin
                owner = 2'(g);
                owned = 1'b1;
            end
        end
        i        = 3'(owner);
        size_g   = size_reg[5*owner +: 5];
        if (size_g == 5'd0)
        begin
            size_g = 5'd1;
        end
        if (size_g > 5'(BATCH_MAX))
        begin
            size_g = 5'(BATCH_MAX);
        end
        fill_inc = {1'b0, fill_reg[channel]} + 5'd1;
        flush    = (fill_inc >= size_g);
    end

    always_comb
    begin
        job           = '0;
        job.kind      = KIND_START;
        job.ch        = channel;
        job.grp       = owner;
        job_valid     = in_take && (opcode != OP_NONE);
        st_we         = 1'b0;
        st_waddr      = {channel, fill_reg[channel]};
        st_wdata      = raw_value[SAMPLE_BITS-1:0];
        case (op_t'(opcode))
            OP_TICK:
            begin
                job.starts  = starts;
                job.has_out = |starts;
            end
            OP_SAMPLE:
            begin
                job.kind    = KIND_BATCH;
                st_we       = in_take && owned;
                job.count   = (owned && flush) ? fill_inc : '0;
                job.has_out = owned && flush;
            end
            OP_READ:
            begin
                job.kind    = KIND_REPLY;
                job.grp     = 2'd0;
                job.value   = latest_reg[channel];
                job.has_out = 1'b1;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
        // drop jobs without results
        if (!job.has_out)
        begin
            job_valid = 1'b0;
        end
        if (i > 3'(NUM_GROUPS))
        begin
            job_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '0;
            masks_reg      <= '0;
            div_reg        <= 32'h0101_0101;
            size_reg       <= 20'h08421;
            counter_reg    <= '0;
            rem_busy_reg   <= 1'b0;
            rem_step_reg   <= '0;
            batch_pend_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                fill_reg[c]   <= '0;
                latest_reg[c] <= '0;
            end
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                res_reg[g] <= '0;
            end
        end
        else
        begin
            // hold input off while a flush still reads the store
            if (batch_done)
            begin
                batch_pend_reg <= 1'b0;
            end
            else if (job_valid && (op_t'(opcode) == OP_SAMPLE))
            begin
                batch_pend_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_ENABLE:   enable_reg <= cfg_data[NUM_GROUPS-1:0];
                    REG_MASKS:    masks_reg  <= cfg_data;
                    REG_DIVIDERS: div_reg    <= cfg_data[31:0];
                    REG_SIZES:    size_reg   <= cfg_data[19:0];
                    default:      enable_reg <= enable_reg;
                endcase
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    fill_reg[c] <= '0;
                end
                if (reg_idx_t'(cfg_index) == REG_DIVIDERS)
                begin
                    rem_busy_reg <= 1'b1;
                    rem_step_reg <= '0;
                    for (int g = 0; g < NUM_GROUPS; g++)
                    begin
                        res_reg[g] <= '0;
                    end
                end
            end
            else if (rem_busy_reg)
            begin
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    res_reg[g] <= res_fold[g];
                end
                rem_step_reg <= rem_step_reg + 4'd1;
                if (rem_step_reg == 4'd15)
                begin
                    rem_busy_reg <= 1'b0;
                end
            end
            else if (in_take)
            begin
                if (opcode == OP_TICK)
                begin
                    counter_reg <= cnt_next;
                    for (int g = 0; g < NUM_GROUPS; g++)
                    begin
                        res_reg[g] <= res_tick[g];
                    end
                end
                else if (opcode == OP_SAMPLE)
                begin
                    latest_reg[channel] <= raw_value[SAMPLE_BITS-1:0];
                    if (owned)
                    begin
                        fill_reg[channel] <= flush ? '0 : fill_inc[FILL_W-1:0];
                    end
                end
            end
        end
    end
endmodule

### sv/agsb_queue.sv
// Short job queue between front and back ends.
module agsb_queue import agsb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output job_t dout,
    output logic empty,
    output logic full
);
    job_t                slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wp_reg;
    logic [QPTR_W-1:0]   rp_reg;
    logic [QPTR_W:0]     cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
        end
    end
endmodule

### sv/agsb_back.sv
// Back end: expands jobs into result items through a one-entry output register.
module agsb_back import agsb_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  job_t                   q_job,
    output logic                   q_pop,
    input  logic [63:0]            masks,
    output logic [STORE_AW-1:0]    st_raddr,
    input  logic [SAMPLE_BITS-1:0] st_rdata,
    output logic                   out_valid,
    output res_t                   out_res,
    input  logic                   out_take,
    output logic                   batch_done
);
    state_t                state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [FILL_W:0]       idx_reg, idx_next;
    logic [1:0]            g_reg, g_next;
    logic                  ovalid_reg, ovalid_next;
    res_t                  ores_reg, ores_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  slot_free;
    logic [NUM_GROUPS-1:0] rest;

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;
    assign slot_free = !ovalid_reg || out_take;
    assign st_raddr  = {job_reg.ch, idx_reg[FILL_W-1:0]};

    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        g_next       = g_reg;
        ovalid_next  = ovalid_reg && !out_take;
        ores_next    = ores_reg;
        rd_pend_next = 1'b0;
        q_pop        = 1'b0;
        batch_done   = 1'b0;
        rest         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    idx_next = '0;
                    g_next   = 2'(NUM_GROUPS - 1);
                    case (q_job.kind)
                        KIND_START: state_next = ST_START;
                        KIND_BATCH: state_next = ST_BATCH;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_START:
            begin
                // walk groups from the highest down
                if (!job_reg.starts[g_reg])
                begin
                    g_next = g_reg - 2'd1;
                end
                else if (slot_free)
                begin
                    for (int g = 0; g < NUM_GROUPS; g++)
                    begin
                        rest[g] = job_reg.starts[g] && (g < int'(g_reg));
                    end
                    ovalid_next = 1'b1;
                    ores_next   = '{kind: KIND_START, grp: g_reg,
                                    mask: masks[16*g_reg +: 16], ch: '0,
                                    value: '0, last: !(|rest)};
                    g_next      = g_reg - 2'd1;
                    if (!(|rest))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BATCH:
            begin
                // read issued this cycle for idx_reg; data next cycle
                if (rd_pend_reg)
                begin
                    if (slot_free)
                    begin
                        ovalid_next = 1'b1;
                        ores_next   = '{kind: KIND_BATCH, grp: job_reg.grp, mask: '0,
                                        ch: job_reg.ch, value: st_rdata,
                                        last: (idx_reg + 1'b1 == job_reg.count)};
                        idx_next    = idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == job_reg.count)
                        begin
                            batch_done = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        rd_pend_next = 1'b1;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '{kind: KIND_REPLY, grp: '0, mask: '0,
                                    ch: job_reg.ch, value: job_reg.value, last: 1'b1};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        ores_reg <= ores_next;
        idx_reg  <= idx_next;
        g_reg    <= g_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            rd_pend_reg <= rd_pend_next;
        end
    end
endmodule

### sv/adc_group_sample_batcher_top.sv
// Top level of the ADC group sample batcher.
// Usage:
//   Input side is a queue: drive opcode/channel/raw_value and push while
//   full is low. Opcode 0 is a conversion tick, 1 a sample, 2 a read.
//   Results are a queue: while empty is low the oldest result is on
//   kind/group_index/channel_mask/channel_id/sample_value/last; pop takes it.
//   Config writes use cfg_valid/cfg_ready with cfg_index and cfg_data; the
//   user must issue them only while the block is idle, which the block does
//   not enforce; each clears all fill counts. A divider write drops cfg_ready
//   and raises full while the per-group counter residues are rebuilt one
//   counter bit per cycle.
//   An item is classified combinationally in the front end and enters a
//   four-deep job queue. The back end takes a job while idle, then emits
//   one start per group to start, highest first, or one reply; a batch
//   of up to 16 samples alternates store reads and emitted samples, and
//   full stays high until its last sample is read. A stalled receiver
//   backs results into the output register, then the queue, then the
//   input.
// Reset: counter, fill counts and latest values clear; registers take
//   their defaults (dividers and batch sizes of one, no groups enabled).
module adc_group_sample_batcher_top import agsb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [3:0]  channel,
    input  logic [15:0] raw_value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [1:0]  group_index,
    output logic [15:0] channel_mask,
    output logic [3:0]  channel_id,
    output logic [15:0] sample_value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
`include "adc_group_sample_batcher_top_assert.svh"

    logic                   q_full, q_empty, q_pop, in_take, jv;
    job_t                   job_in, job_out;
    logic                   st_we;
    logic [STORE_AW-1:0]    st_waddr, st_raddr;
    logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;
    logic [63:0]            masks;
    logic                   ov;
    res_t                   res;
    logic                   front_busy;
    logic                   batch_done;

    assign full      = q_full || front_busy;
    assign in_take   = push && !full;

    agsb_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .in_take,
        .opcode, .channel, .raw_value, .batch_done, .busy(front_busy),
        .st_we, .st_waddr, .st_wdata,
        .job_valid(jv), .job(job_in), .masks
    );

    agsb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH), .AW(STORE_AW)) u_store (
        .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    agsb_queue u_queue (
        .clk, .rst_n, .push(jv), .din(job_in), .pop(q_pop),
        .dout(job_out), .empty(q_empty), .full(q_full)
    );

    agsb_back u_back (
        .clk, .rst_n, .q_empty, .q_job(job_out), .q_pop, .masks,
        .st_raddr, .st_rdata, .out_valid(ov), .out_res(res),
        .out_take(pop), .batch_done
    );

    assign empty        = !ov;
    assign kind         = res.kind;
    assign group_index  = res.grp;
    assign channel_mask = res.mask;
    assign channel_id   = res.ch;
    assign sample_value = res.value;
    assign last         = res.last;

    `AGSB_ASSERT_IMPL(a_no_pop_empty_q, q_pop, !q_empty)
    `AGSB_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(sample_value))
    `AGSB_ASSERT_IMPL(a_kind_legal, !empty, kind != KIND_RSVD)
endmodule

### dv/tb_top.sv
// Self-checking testbench of the ADC group sample batcher.
`timescale 1ns / 100ps

module tb_top;
    import agsb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [3:0]  channel;
    logic [15:0] raw_value;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [1:0]  group_index;
    logic [15:0] channel_mask;
    logic [3:0]  channel_id;
    logic [15:0] sample_value;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 200;

    adc_group_sample_batcher_top DUT (.*);

    // predictor state
    logic [3:0]  mdl_enable;
    logic [63:0] mdl_masks;
    logic [31:0] mdl_dividers;
    logic [19:0] mdl_sizes;
    logic [15:0] mdl_counter;
    logic [15:0] mdl_store [256];
    logic [3:0]  mdl_fill [16];
    logic [15:0] mdl_latest [16];

    res_t expected_results [$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;
    int   hold_count = 0;
    int   quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int group_divider(int g);
        logic [7:0] d;
        d = mdl_dividers[8*g +: 8];
        return (d == 0) ? 1 : int'(d);
    endfunction

    function automatic int group_batch_len(int g);
        logic [4:0] s;
        s = mdl_sizes[5*g +: 5];
        if (s == 0) return 1;
        if (s > BATCH_MAX) return BATCH_MAX;
        return int'(s);
    endfunction

    task automatic push_result(kind_t k, logic [1:0] g, logic [15:0] m, logic [3:0] c,
                               logic [15:0] v, logic l);
        res_t r;
        r.kind = k;
        r.grp = g;
        r.mask = m;
        r.ch = c;
        r.value = v;
        r.last = l;
        expected_results.push_back(r);
    endtask

    task automatic predict_item(op_t op, logic [3:0] ch, logic [15:0] raw);
        int n;
        int fill;
        n = 0;
        case (op)
            OP_TICK:
            begin
                mdl_counter = mdl_counter + 16'd1;
                for (int g = NUM_GROUPS - 1; g >= 0; g--)
                begin
                    if (mdl_enable[g] && (int'(mdl_counter) % group_divider(g)) == 0)
                    begin
                        push_result(KIND_START, 2'(g), mdl_masks[16*g +: 16], 4'd0,
                                    16'd0, 1'b0);
                        n++;
                    end
                end
                if (n > 0) expected_results[$].last = 1'b1;
            end
            OP_SAMPLE:
            begin
                mdl_latest[ch] = raw;
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    if (mdl_enable[g] && mdl_masks[16*g + ch])
                    begin
                        fill = int'(mdl_fill[ch]);
                        mdl_store[{ch, 4'(fill)}] = raw;
                        fill++;
                        if (fill >= group_batch_len(g))
                        begin
                            for (int i = 0; i < fill; i++)
                                push_result(KIND_BATCH, 2'(g), 16'd0, ch,
                                            mdl_store[{ch, 4'(i)}], i + 1 == fill);
                            fill = 0;
                        end
                        mdl_fill[ch] = 4'(fill);
                        break;
                    end
                end
            end
            OP_READ:
                push_result(KIND_REPLY, 2'd0, 16'd0, ch, mdl_latest[ch], 1'b1);
            default: ;
        endcase
    endtask

    // push stays high after an accepted item until the next idle cycle
    task automatic send_item(op_t op, logic [3:0] ch, logic [15:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        channel <= ch;
        raw_value <= raw;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(op, ch, raw);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE:   mdl_enable = data[3:0];
            REG_MASKS:    mdl_masks = data;
            REG_DIVIDERS: mdl_dividers = data[31:0];
            default:      mdl_sizes = data[19:0];
        endcase
        for (int i = 0; i < 16; i++)
            mdl_fill[i] = '0;
    endtask

    task automatic configure(logic [3:0] en, logic [63:0] masks, logic [31:0] divs,
                             logic [19:0] sizes);
        write_reg(REG_MASKS, masks);
        write_reg(REG_DIVIDERS, {32'($urandom), divs});
        write_reg(REG_SIZES, {44'($urandom), sizes});
        write_reg(REG_ENABLE, {60'($urandom), en});
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send_item(OP_TICK, 4'($urandom), 16'($urandom));
        else if (r < 80)
            send_item(OP_SAMPLE, 4'($urandom), 16'($urandom));
        else if (r < 97)
            send_item(OP_READ, 4'($urandom), 16'($urandom));
        else
            send_item(OP_NONE, 4'($urandom), 16'($urandom));
    endtask

    task automatic random_config();
        configure(4'($urandom), {$urandom, $urandom}, $urandom,
                  20'($urandom) & 20'h7BDEF);
    endtask

    task automatic test_directed();
        configure(4'hF, 64'h8000_0F00_00F0_000F, 32'h0004_0201, 20'h0_8421);
        send_item(OP_READ, 4'd15, 16'hFFFF);
        send_item(OP_SAMPLE, 4'd0, 16'hFFFF);
        send_item(OP_SAMPLE, 4'd4, 16'h0000);
        send_item(OP_SAMPLE, 4'd5, 16'hA5A5);
        send_item(OP_SAMPLE, 4'd15, 16'h5A5A);
        send_item(OP_SAMPLE, 4'd12, 16'h1234);
        send_item(OP_READ, 4'd0, 16'h0);
        send_item(OP_READ, 4'd12, 16'h0);
        for (int i = 0; i < 4; i++)
            send_item(OP_TICK, 4'd0, 16'h0);
        send_item(OP_NONE, 4'd3, 16'hFFFF);
        // largest batch, unmapped channel and empty mask
        configure(4'h3, 64'h0000_0000_0000_0002, 32'hFFFF_FF00, 20'hFFFF0);
        for (int i = 0; i < 16; i++)
            send_item(OP_SAMPLE, 4'd1, 16'(i * 4099));
        send_item(OP_SAMPLE, 4'd9, 16'h0BAD);
        send_item(OP_TICK, 4'd0, 16'h0);
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
                random_config();
            random_item();
        end
    endtask

    task automatic test_backpressure();
        configure(4'h1, 64'hFFFF, 32'h1, 20'h10);
        recv_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_READ, 4'($urandom), 16'($urandom));
        recv_hold = 1'b0;
        wait_idle();
        for (int i = 0; i < 10; i++)
            send_item(OP_READ, 4'($urandom), 16'd0);
    endtask

    // receiver: a hold request stalls pop for a counted stretch
    always @(posedge clk)
    begin
        if (recv_hold && (hold_count < HOLD_CYCLES))
        begin
            pop <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
            if (!recv_hold)
                hold_count <= 0;
        end
    end

    always @(posedge clk)
    begin
        res_t exp;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind=%0d", kind);
                errors++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (kind !== exp.kind)
                begin
                    $error("kind expected %0d actual %0d", exp.kind, kind);
                    errors++;
                end
                if (group_index !== exp.grp)
                begin
                    $error("group_index expected %0d actual %0d", exp.grp, group_index);
                    errors++;
                end
                if (channel_mask !== exp.mask)
                begin
                    $error("channel_mask expected %h actual %h", exp.mask, channel_mask);
                    errors++;
                end
                if (channel_id !== exp.ch)
                begin
                    $error("channel_id expected %0d actual %0d", exp.ch, channel_id);
                    errors++;
                end
                if (sample_value !== exp.value)
                begin
                    $error("sample_value expected %h actual %h", exp.value, sample_value);
                    errors++;
                end
                if (last !== exp.last)
                begin
                    $error("last expected %0d actual %0d", exp.last, last);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no accepted item of any kind
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = OP_TICK;
        channel = '0;
        raw_value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data = '0;
        errors = 0;
        recv_hold = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 63;
        mdl_enable = '0;
        mdl_masks = '0;
        mdl_dividers = 32'h0101_0101;
        mdl_sizes = 20'h0_8421;
        mdl_counter = '0;
        for (int i = 0; i < 16; i++)
        begin
            mdl_fill[i] = '0;
            mdl_latest[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(130);
        send_idle_pct = 63;
        recv_idle_pct = 9;
        test_random(130);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(130);
        wait_idle();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### adc_group_sample_batcher_top.f
+incdir+sv
sv/agsb_pkg.sv
sv/agsb_ram.sv
sv/agsb_front.sv
sv/agsb_queue.sv
sv/agsb_back.sv
sv/adc_group_sample_batcher_top.sv
dv/tb_top.sv
